/* design/stereo_pingpong_delay_defines.svh */
// Assertion macros shared by the checker of the stereo ping-pong delay.
`ifndef STEREO_PINGPONG_DELAY_DEFINES_SVH
`define STEREO_PINGPONG_DELAY_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define SPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/spd_pkg.sv */
// Types, constants and reset values of the stereo ping-pong delay.
package spd_pkg;

  localparam int SMP_W              = 16;
  localparam int GAIN_W             = 16;
  localparam int DELAY_W            = 16;
  localparam int Q_FRAC             = 15;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 16;
  localparam int LINE_ADDR_BITS_DEF = 16;
  localparam int SAMPLE_BITS_DEF    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PINGPONG = 3'd0,
    REG_LEFT_DLY = 3'd1,
    REG_RIGHT_DLY = 3'd2,
    REG_FB_GAIN  = 3'd3,
    REG_DRY_GAIN = 3'd4,
    REG_WET_GAIN = 3'd5
  } cfg_reg_t;

  localparam logic               PINGPONG_RST = 1'b1;
  localparam logic [DELAY_W-1:0] LEFT_DLY_RST = 16'd48000;
  localparam logic [DELAY_W-1:0] RIGHT_DLY_RST = 16'd48000;
  localparam logic [GAIN_W-1:0]  FB_GAIN_RST  = 16'd6554;
  localparam logic [GAIN_W-1:0]  DRY_GAIN_RST = 16'd23198;
  localparam logic [GAIN_W-1:0]  WET_GAIN_RST = 16'd2068;

endpackage

/* design/spd_in_if.sv */
// Input stream interface carrying one stereo sample pair per transaction.
interface spd_in_if import spd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] left_in;
  logic signed [SMP_W-1:0] right_in;

  modport source(output valid, output left_in, output right_in, input ready);
  modport sink(input valid, input left_in, input right_in, output ready);
endinterface

/* design/spd_out_if.sv */
// Output stream interface carrying one processed stereo sample pair per transaction.
interface spd_out_if import spd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] left_out;
  logic signed [SMP_W-1:0] right_out;

  modport source(output valid, output left_out, output right_out, input ready);
  modport sink(input valid, input left_out, input right_out, output ready);
endinterface

/* design/spd_mac.sv */
// Per-channel gain arithmetic: feedback sum and dry/wet mix with rounding and saturation.
module spd_mac import spd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic signed [SMP_W-1:0]       x,
  input  logic signed [SAMPLE_BITS-1:0] y,
  input  logic [GAIN_W-1:0]             fb_gain,
  input  logic [GAIN_W-1:0]             dry_gain,
  input  logic [GAIN_W-1:0]             wet_gain,
  output logic signed [SAMPLE_BITS-1:0] fb_sum,
  output logic signed [SMP_W-1:0]       dout
);

  localparam int YP_W  = SAMPLE_BITS + GAIN_W + 1;
  localparam int XP_W  = SMP_W + GAIN_W + 1;
  localparam int PW    = (YP_W > XP_W) ? YP_W : XP_W;
  localparam int ACC_W = PW + 2;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (Q_FRAC - 1));
  localparam logic signed [ACC_W-1:0] SMAX =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

  logic signed [YP_W-1:0]          fb_prod;
  logic signed [YP_W-1:0]          wet_prod;
  logic signed [XP_W-1:0]          dry_prod;
  logic signed [SMP_W+Q_FRAC-1:0]  x_sh;
  logic signed [ACC_W-1:0]         fb_acc;
  logic signed [ACC_W-1:0]         out_acc;
  logic signed [SAMPLE_BITS-1:0]   out_sat;

  function automatic logic signed [SAMPLE_BITS-1:0] rnd_sat(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] t;
    t = (v + HALF) >>> Q_FRAC;
    if (t > SMAX) begin
      t = SMAX;
    end else if (t < SMIN) begin
      t = SMIN;
    end
    return SAMPLE_BITS'(t);
  endfunction

  always_comb begin
    x_sh     = $signed({x, {Q_FRAC{1'b0}}});
    fb_prod  = $signed({1'b0, fb_gain}) * y;
    wet_prod = $signed({1'b0, wet_gain}) * y;
    dry_prod = $signed({1'b0, dry_gain}) * x;
    fb_acc   = ACC_W'(x_sh) + ACC_W'(fb_prod);
    out_acc  = ACC_W'(dry_prod) + ACC_W'(wet_prod);
    fb_sum   = rnd_sat(fb_acc);
    out_sat  = rnd_sat(out_acc);
    dout     = SMP_W'(out_sat);
  end

endmodule

/* design/stereo_pingpong_delay.sv */
// Stereo feedback delay with ping-pong crossing, top level.
// Pipeline: an accepted transaction waits in the stage-1 registers and moves to the
// output register at commit. Throughput: one transaction per cycle unless the output
// stalls; line memories are read at accept and written at commit, forwarding between.
// Reset: synchronous; both lines read as zero until written, tracked by the write
// position and a wrap flag, so no clearing pass is needed and input is taken at once.
module stereo_pingpong_delay import spd_pkg::*; #(
  parameter int ADDR_BITS   = LINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  spd_in_if.sink                in_bus,
  spd_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LINE_DEPTH = 1 << ADDR_BITS;

  logic [SAMPLE_BITS-1:0] left_mem  [LINE_DEPTH];
  logic [SAMPLE_BITS-1:0] right_mem [LINE_DEPTH];

  logic               pingpong_r;
  logic [DELAY_W-1:0] left_dly_r;
  logic [DELAY_W-1:0] right_dly_r;
  logic [GAIN_W-1:0]  fb_gain_r;
  logic [GAIN_W-1:0]  dry_gain_r;
  logic [GAIN_W-1:0]  wet_gain_r;

  logic [ADDR_BITS-1:0] wp_r;
  logic                 wrap_r;
  logic                 s1_v_r;
  logic                 out_v_r;

  logic signed [SMP_W-1:0]       s1_xl_r;
  logic signed [SMP_W-1:0]       s1_xr_r;
  logic [ADDR_BITS-1:0]          s1_wp_r;
  logic                          s1_lvld_r;
  logic                          s1_rvld_r;
  logic                          s1_lfwd_r;
  logic                          s1_rfwd_r;
  logic signed [SAMPLE_BITS-1:0] s1_lfwd_d_r;
  logic signed [SAMPLE_BITS-1:0] s1_rfwd_d_r;
  logic [SAMPLE_BITS-1:0]        lrd_r;
  logic [SAMPLE_BITS-1:0]        rrd_r;
  logic signed [SMP_W-1:0]       out_l_r;
  logic signed [SMP_W-1:0]       out_r_r;

  logic                          accept;
  logic                          commit;
  logic                          in_ready;
  logic [ADDR_BITS-1:0]          raddr_l;
  logic [ADDR_BITS-1:0]          raddr_r;
  logic                          vld_l;
  logic                          vld_r;
  logic                          fwd_l;
  logic                          fwd_r;
  logic signed [SAMPLE_BITS-1:0] yl;
  logic signed [SAMPLE_BITS-1:0] yr;
  logic signed [SAMPLE_BITS-1:0] dl;
  logic signed [SAMPLE_BITS-1:0] dr;
  logic signed [SAMPLE_BITS-1:0] wl;
  logic signed [SAMPLE_BITS-1:0] wr;
  logic signed [SMP_W-1:0]       ol;
  logic signed [SMP_W-1:0]       orr;

  assign commit   = s1_v_r && (!out_v_r || out_bus.ready);
  assign in_ready = !s1_v_r || commit;
  assign accept   = in_bus.valid && in_ready;

  assign in_bus.ready      = in_ready;
  assign out_bus.valid     = out_v_r;
  assign out_bus.left_out  = out_l_r;
  assign out_bus.right_out = out_r_r;

  always_comb begin
    raddr_l = wp_r - ADDR_BITS'(left_dly_r);
    raddr_r = wp_r - ADDR_BITS'(right_dly_r);
    vld_l   = wrap_r || (raddr_l < wp_r);
    vld_r   = wrap_r || (raddr_r < wp_r);
    fwd_l   = commit && (raddr_l == s1_wp_r);
    fwd_r   = commit && (raddr_r == s1_wp_r);
  end

  always_comb begin
    if (s1_lfwd_r) begin
      yl = s1_lfwd_d_r;
    end else if (s1_lvld_r) begin
      yl = $signed(lrd_r);
    end else begin
      yl = '0;
    end
    if (s1_rfwd_r) begin
      yr = s1_rfwd_d_r;
    end else if (s1_rvld_r) begin
      yr = $signed(rrd_r);
    end else begin
      yr = '0;
    end
  end

  spd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac_l (
    .x        (s1_xl_r),
    .y        (yl),
    .fb_gain  (fb_gain_r),
    .dry_gain (dry_gain_r),
    .wet_gain (wet_gain_r),
    .fb_sum   (dl),
    .dout     (ol)
  );

  spd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac_r (
    .x        (s1_xr_r),
    .y        (yr),
    .fb_gain  (fb_gain_r),
    .dry_gain (dry_gain_r),
    .wet_gain (wet_gain_r),
    .fb_sum   (dr),
    .dout     (orr)
  );

  assign wl = pingpong_r ? dr : dl;
  assign wr = pingpong_r ? dl : dr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pingpong_r  <= PINGPONG_RST;
      left_dly_r  <= LEFT_DLY_RST;
      right_dly_r <= RIGHT_DLY_RST;
      fb_gain_r   <= FB_GAIN_RST;
      dry_gain_r  <= DRY_GAIN_RST;
      wet_gain_r  <= WET_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PINGPONG:  pingpong_r  <= cfg_data[0];
        REG_LEFT_DLY:  left_dly_r  <= cfg_data[DELAY_W-1:0];
        REG_RIGHT_DLY: right_dly_r <= cfg_data[DELAY_W-1:0];
        REG_FB_GAIN:   fb_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_DRY_GAIN:  dry_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_WET_GAIN:  wet_gain_r  <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      wrap_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        wp_r <= wp_r + 1'b1;
        if (&wp_r) begin
          wrap_r <= 1'b1;
        end
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (commit) begin
        s1_v_r <= 1'b0;
      end
      if (commit) begin
        out_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_xl_r     <= in_bus.left_in;
      s1_xr_r     <= in_bus.right_in;
      s1_wp_r     <= wp_r;
      s1_lvld_r   <= vld_l;
      s1_rvld_r   <= vld_r;
      s1_lfwd_r   <= fwd_l;
      s1_rfwd_r   <= fwd_r;
      s1_lfwd_d_r <= wl;
      s1_rfwd_d_r <= wr;
    end
    if (commit) begin
      out_l_r <= ol;
      out_r_r <= orr;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      left_mem[s1_wp_r]  <= wl;
      right_mem[s1_wp_r] <= wr;
    end
    if (accept) begin
      lrd_r <= left_mem[raddr_l];
      rrd_r <= right_mem[raddr_r];
    end
  end

endmodule

/* design/spd_checker.sv */
// Port-level assertion checker for the stereo ping-pong delay, with its bind.
`include "stereo_pingpong_delay_defines.svh"

module spd_checker import spd_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SMP_W-1:0] out_left,
  input logic signed [SMP_W-1:0] out_right
);

  // The output register is empty after reset.
  `SPD_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")

  // Input back-pressure only occurs when a finished result is waiting.
  `SPD_ASSERT(a_stall_full, !in_ready |-> out_valid, "input stalled with empty output")

  // After an accepted transaction passes the stage-1 registers, the output register holds a valid result.
  `SPD_ASSERT(a_latency, in_valid && in_ready |=> ##1 out_valid, "result missing after accept")

  `SPD_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right),
    "stalled output changed")

endmodule

bind stereo_pingpong_delay spd_checker u_spd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_left  (out_bus.left_out),
  .out_right (out_bus.right_out)
);
